>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked property checks that are compiled out when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising edge outside reset.
`define RS_ASSERT(lbl, clk_sig, rst_sig, prop) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (prop)) \
    else $error("assertion failed");

// Expression must never be true at a rising edge outside reset.
`define RS_ASSERT_NEVER(lbl, clk_sig, rst_sig, expr) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) !(expr)) \
    else $error("forbidden condition seen");

`else

`define RS_ASSERT(lbl, clk_sig, rst_sig, prop)
`define RS_ASSERT_NEVER(lbl, clk_sig, rst_sig, expr)

`endif

`endif

>>> rtl/rs485fr_pkg.sv
// ---------------------------------------------------------------------------
// rs485fr_pkg
// Shared types, codes and constants of the RS-485 frame receiver.
// ---------------------------------------------------------------------------
`default_nettype none

package rs485fr_pkg;

  localparam int CounterWidth   = 32;
  localparam int MaxFrameLength = 64;
  localparam int NumCounters    = 10;

  // Statistic counter slots.
  localparam int CNT_TO_ME          = 0;
  localparam int CNT_GOOD_TO_ME     = 1;
  localparam int CNT_TO_OTHERS      = 2;
  localparam int CNT_BROADCAST      = 3;
  localparam int CNT_GOOD_TO_OTHERS = 4;
  localparam int CNT_TIMEOUT        = 5;
  localparam int CNT_FUNC_NOT_SUPP  = 6;
  localparam int CNT_WAIT_START     = 7;
  localparam int CNT_WAIT_STOP      = 8;
  localparam int CNT_BAD_CHECK      = 9;

  localparam logic [7:0] CHECK_SEED = 8'hFF;

  // Request commands.
  typedef enum logic [1:0] {
    CMD_BYTE  = 2'd0,
    CMD_FLUSH = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_START_CODE   = 3'd0,
    REG_STOP_CODE    = 3'd1,
    REG_OWN_ADDRESS  = 3'd2,
    REG_BCAST_ADDR   = 3'd3,
    REG_WRITE_ALL    = 3'd4,
    REG_FRAME_LENGTH = 3'd5
  } reg_idx_t;

  // Result event codes.
  typedef enum logic [3:0] {
    EV_NONE       = 4'd0,
    EV_SKIPPED    = 4'd1,
    EV_OWN_ADDR   = 4'd2,
    EV_BROADCAST  = 4'd3,
    EV_OTHER_ADDR = 4'd4,
    EV_BAD_FUNC   = 4'd5,
    EV_BAD_CHECK  = 4'd6,
    EV_NO_STOP    = 4'd7,
    EV_GOOD_OWN   = 4'd8,
    EV_GOOD_OTHER = 4'd9,
    EV_FLUSHED    = 4'd10
  } ev_t;

  // Parser states, one-hot.
  typedef enum logic [5:0] {
    ST_START = 6'b000001,
    ST_ADDR  = 6'b000010,
    ST_FUNC  = 6'b000100,
    ST_DATA  = 6'b001000,
    ST_CHECK = 6'b010000,
    ST_STOP  = 6'b100000
  } pstate_t;

  // Reported state numbers.
  localparam logic [2:0] SN_START = 3'd0;
  localparam logic [2:0] SN_ADDR  = 3'd1;
  localparam logic [2:0] SN_FUNC  = 3'd2;
  localparam logic [2:0] SN_DATA  = 3'd3;
  localparam logic [2:0] SN_CHECK = 3'd4;
  localparam logic [2:0] SN_STOP  = 3'd5;

  // Live configuration.
  typedef struct packed {
    logic [7:0] start_code;
    logic [7:0] stop_code;
    logic [7:0] own_address;
    logic [7:0] broadcast_address;
    logic [7:0] write_all_code;
    logic [6:0] frame_length;
  } cfg_t;

  // Parser result for one request, plus counter increments.
  typedef struct packed {
    ev_t                    code;
    logic                   reply;
    logic [2:0]             prior;
    logic [NumCounters-1:0] bump;
  } evt_t;

  // Encode a one-hot parser state as its reported number.
  function automatic logic [2:0] state_num(input pstate_t st);
    logic [2:0] num;
    case (st)
      ST_ADDR:  num = SN_ADDR;
      ST_FUNC:  num = SN_FUNC;
      ST_DATA:  num = SN_DATA;
      ST_CHECK: num = SN_CHECK;
      ST_STOP:  num = SN_STOP;
      default:  num = SN_START;
    endcase
    return num;
  endfunction

endpackage

`default_nettype wire

>>> rtl/rs485fr_parser.sv
// ---------------------------------------------------------------------------
// rs485fr_parser
// Frame parser state machine with running XOR check and byte count.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rs485fr_parser
  import rs485fr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       en,
  input  wire cmd_t       cmd,
  input  wire logic [7:0] rx_byte,
  input  wire cfg_t       cfg,
  output evt_t            evt
);

  pstate_t    state, state_next;
  logic [6:0] byte_count, byte_count_next;
  logic [7:0] check, check_next;
  logic       to_me, to_me_next;
  logic [6:0] len;
  logic       data_done;

  // Effective frame length, saturated to the largest supported frame.
  assign len = (cfg.frame_length > 7'(MaxFrameLength)) ? 7'(MaxFrameLength)
                                                       : cfg.frame_length;
  // Data phase ends once stored bytes reach length minus three.
  assign data_done = ({1'b0, byte_count} + 8'd3) >= {1'b0, len};

  // Next-state and event logic.
  always_comb begin
    state_next      = state;
    byte_count_next = byte_count;
    check_next      = check;
    to_me_next      = to_me;
    evt             = '0;
    evt.code        = EV_NONE;
    if (en) begin
      case (cmd)
        CMD_FLUSH: begin
          evt.prior             = state_num(state);
          evt.bump[CNT_TIMEOUT] = 1'b1;
          evt.code              = EV_FLUSHED;
          state_next            = ST_START;
          byte_count_next       = '0;
          check_next            = CHECK_SEED;
        end
        CMD_BYTE: begin
          case (state)
            ST_ADDR: begin
              if (rx_byte == cfg.own_address) begin
                evt.bump[CNT_TO_ME] = 1'b1;
                evt.code            = EV_OWN_ADDR;
                to_me_next          = 1'b1;
              end else begin
                if (rx_byte == cfg.broadcast_address) begin
                  evt.bump[CNT_BROADCAST] = 1'b1;
                  evt.code                = EV_BROADCAST;
                end else begin
                  evt.bump[CNT_TO_OTHERS] = 1'b1;
                  evt.code                = EV_OTHER_ADDR;
                end
                to_me_next = 1'b0;
              end
              state_next = ST_FUNC;
            end
            ST_FUNC: begin
              if (rx_byte == cfg.write_all_code) begin
                state_next = ST_DATA;
              end else begin
                evt.bump[CNT_FUNC_NOT_SUPP] = 1'b1;
                evt.code                    = EV_BAD_FUNC;
                state_next                  = ST_START;
              end
            end
            ST_DATA: begin
              if (data_done) begin
                state_next = ST_CHECK;
              end
            end
            ST_CHECK: begin
              if (rx_byte == check) begin
                state_next = ST_STOP;
              end else begin
                evt.bump[CNT_BAD_CHECK] = 1'b1;
                evt.code                = EV_BAD_CHECK;
                state_next              = ST_START;
              end
            end
            ST_STOP: begin
              if (rx_byte == cfg.stop_code) begin
                if (to_me) begin
                  evt.bump[CNT_GOOD_TO_ME] = 1'b1;
                  evt.reply                = 1'b1;
                  evt.code                 = EV_GOOD_OWN;
                end else begin
                  evt.bump[CNT_GOOD_TO_OTHERS] = 1'b1;
                  evt.code                     = EV_GOOD_OTHER;
                end
              end else begin
                evt.bump[CNT_WAIT_STOP] = 1'b1;
                evt.code                = EV_NO_STOP;
              end
              state_next = ST_START;
            end
            default: begin
              if (rx_byte == cfg.start_code) begin
                state_next = ST_ADDR;
              end else begin
                evt.bump[CNT_WAIT_START] = 1'b1;
                evt.code                 = EV_SKIPPED;
                state_next               = ST_START;
              end
            end
          endcase
          // A byte that keeps the frame open joins the check and the count;
          // a byte that ends or rejects the frame restarts both.
          if (state_next != ST_START) begin
            check_next = check ^ rx_byte;
            if (byte_count != 7'h7F) begin
              byte_count_next = byte_count + 7'd1;
            end
          end else begin
            byte_count_next = '0;
            check_next      = CHECK_SEED;
          end
        end
        default: begin
          // Counter read and clear leave the parser untouched.
        end
      endcase
    end
  end

  // Parser registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_START;
      byte_count <= '0;
      check      <= CHECK_SEED;
      to_me      <= 1'b0;
    end else begin
      state      <= state_next;
      byte_count <= byte_count_next;
      check      <= check_next;
      to_me      <= to_me_next;
    end
  end

  // A reply is only granted at the stop byte of a frame addressed to us.
  `RS_ASSERT(a_reply_own, clk, rst, evt.reply |-> (to_me && state == ST_STOP))
  // While waiting for a start byte, count and check sit at their seeds.
  `RS_ASSERT(a_idle_seed, clk, rst,
    (state == ST_START) |-> (byte_count == 7'd0 && check == CHECK_SEED))
  // A flush always returns the parser to waiting for start.
  `RS_ASSERT(a_flush_restart, clk, rst, (en && cmd == CMD_FLUSH) |=> (state == ST_START))
  // Every event that counts something bumps exactly one counter.
  `RS_ASSERT_NEVER(a_one_bump, clk, rst,
    (evt.code != EV_NONE) && !$onehot(evt.bump))

endmodule

`default_nettype wire

>>> rtl/rs485fr_stats.sv
// ---------------------------------------------------------------------------
// rs485fr_stats
// Ten wrapping statistic counters with clear and indexed read.
// ---------------------------------------------------------------------------
`default_nettype none

module rs485fr_stats
  import rs485fr_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    en,
  input  wire cmd_t                    cmd,
  input  wire logic [3:0]              counter_index,
  input  wire logic [NumCounters-1:0]  bump,
  output logic [CounterWidth-1:0]      counter_value
);

  logic [CounterWidth-1:0] counters [NumCounters];

  // Per-counter increment or global clear.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumCounters; i++) begin
        counters[i] <= '0;
      end
    end else if (en && cmd == CMD_CLEAR) begin
      for (int i = 0; i < NumCounters; i++) begin
        counters[i] <= '0;
      end
    end else if (en) begin
      for (int i = 0; i < NumCounters; i++) begin
        if (bump[i]) begin
          counters[i] <= counters[i] + CounterWidth'(1);
        end
      end
    end
  end

  // Read port: out-of-range indexes and other commands give zero.
  always_comb begin
    counter_value = '0;
    if (cmd == CMD_READ && counter_index < 4'(NumCounters)) begin
      counter_value = counters[counter_index];
    end
  end

endmodule

`default_nettype wire

>>> rtl/rs485_frame_receiver_core.sv
// ---------------------------------------------------------------------------
// rs485_frame_receiver_core
// RS-485 frame receiver: byte parser, statistics and stream handshakes.
// ---------------------------------------------------------------------------
// Each request (a line byte, a timeout flush, a counter read or a counter
// clear) gives exactly one result. Requests are taken one per clock while
// the result side does not stall: a request is captured in the input
// register, handled by the parser and the counters once the result
// register can take it, and lands in the result register at that clock
// edge. The single parser stage sets that rate; a stalled result register
// holds one result while one more request waits in the input register.
// Configuration writes take effect at once and must be made while idle; the block does not enforce it.
`default_nettype none

module rs485_frame_receiver_core
  import rs485fr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration write port.
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [7:0]  cfg_wdata,
  // Request stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // rx_byte[7:0], counter_index[11:8], zero
  input  wire logic [1:0]  s_axis_tuser,   // cmd[1:0]
  // Result stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata    // event_res[3:0], reply_request[4],
                                           // prior_state[7:5], counter_value[39:8]
);

  cfg_t                    cfg;
  logic                    in_valid;
  cmd_t                    in_cmd;
  logic [7:0]              in_byte;
  logic [3:0]              in_index;
  logic                    advance;
  evt_t                    evt;
  logic [CounterWidth-1:0] cval;
  logic                    out_valid;
  logic [39:0]             out_data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_code        <= 8'd126;
      cfg.stop_code         <= 8'd127;
      cfg.own_address       <= 8'd1;
      cfg.broadcast_address <= 8'd255;
      cfg.write_all_code    <= 8'd1;
      cfg.frame_length      <= 7'd12;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_CODE:   cfg.start_code        <= cfg_wdata;
        REG_STOP_CODE:    cfg.stop_code         <= cfg_wdata;
        REG_OWN_ADDRESS:  cfg.own_address       <= cfg_wdata;
        REG_BCAST_ADDR:   cfg.broadcast_address <= cfg_wdata;
        REG_WRITE_ALL:    cfg.write_all_code    <= cfg_wdata;
        REG_FRAME_LENGTH: cfg.frame_length      <= cfg_wdata[6:0];
        default: begin
        end
      endcase
    end
  end

  // The held request is processed when the result register can take it.
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd   <= cmd_t'(s_axis_tuser);
      in_byte  <= s_axis_tdata[7:0];
      in_index <= s_axis_tdata[11:8];
    end
  end

  rs485fr_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .en      (advance),
    .cmd     (in_cmd),
    .rx_byte (in_byte),
    .cfg     (cfg),
    .evt     (evt)
  );

  rs485fr_stats u_stats (
    .clk           (clk),
    .rst           (rst),
    .en            (advance),
    .cmd           (in_cmd),
    .counter_index (in_index),
    .bump          (evt.bump),
    .counter_value (cval)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= {cval, evt.prior, evt.reply, evt.code};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Stream testbench of the RS-485 frame receiver core. Line bytes, flushes,
// counter reads and counter clears go in as requests. A scoreboard parses
// each accepted request and keeps the expected result and statistics. Each
// result is compared field by field. Both sides stall at random, and the
// parser runs under several register settings.
// ---------------------------------------------------------------------------
module tb_top
  import rs485fr_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // One expected result of the receiver.
  typedef struct {
    ev_t         ev;
    logic        reply;
    logic [2:0]  prior;
    logic [31:0] cval;
  } frame_result_t;

  // Frame parser shadow plus the queue of results still owed by the block.
  class frame_scoreboard;
    cfg_t            cfg;
    logic [2:0]      parse_st;
    logic [6:0]      byte_cnt;
    bit              to_me;
    logic [7:0]      check_acc;
    logic [31:0]     stats [NumCounters];
    frame_result_t   pending_events [$];
    int              errors;

    function new();
      cfg.start_code        = 8'd126;
      cfg.stop_code         = 8'd127;
      cfg.own_address       = 8'd1;
      cfg.broadcast_address = 8'd255;
      cfg.write_all_code    = 8'd1;
      cfg.frame_length      = 7'd12;
      to_me = 1'b0;
      foreach (stats[i]) stats[i] = '0;
      errors = 0;
      restart();
    endfunction

    function void restart();
      parse_st  = SN_START;
      byte_cnt  = '0;
      check_acc = CHECK_SEED;
    endfunction

    function void bump(int idx);
      stats[idx] = stats[idx] + 32'd1;
    endfunction

    function int pending();
      return pending_events.size();
    endfunction

    function void write_reg(reg_idx_t r, logic [7:0] v);
      case (r)
        REG_START_CODE:   cfg.start_code = v;
        REG_STOP_CODE:    cfg.stop_code = v;
        REG_OWN_ADDRESS:  cfg.own_address = v;
        REG_BCAST_ADDR:   cfg.broadcast_address = v;
        REG_WRITE_ALL:    cfg.write_all_code = v;
        REG_FRAME_LENGTH: cfg.frame_length = v[6:0];
        default: ;
      endcase
    endfunction

    // Parse one accepted request and queue the result it must give.
    function void note_request(cmd_t c, logic [7:0] b, logic [3:0] ix);
      frame_result_t res;
      int len;
      res.ev = EV_NONE;
      res.reply = 1'b0;
      res.prior = SN_START;
      res.cval = '0;
      len = int'(cfg.frame_length);
      if (len > MaxFrameLength) len = MaxFrameLength;
      case (c)
        CMD_FLUSH: begin
          res.prior = parse_st;
          bump(CNT_TIMEOUT);
          restart();
          res.ev = EV_FLUSHED;
        end
        CMD_READ: begin
          if (ix < NumCounters) res.cval = stats[ix];
        end
        CMD_CLEAR: begin
          foreach (stats[i]) stats[i] = '0;
        end
        default: begin
          case (parse_st)
            SN_ADDR: begin
              if (b == cfg.own_address) begin
                bump(CNT_TO_ME);
                to_me = 1'b1;
                res.ev = EV_OWN_ADDR;
              end else begin
                if (b == cfg.broadcast_address) begin
                  bump(CNT_BROADCAST);
                  res.ev = EV_BROADCAST;
                end else begin
                  bump(CNT_TO_OTHERS);
                  res.ev = EV_OTHER_ADDR;
                end
                to_me = 1'b0;
              end
              parse_st = SN_FUNC;
            end
            SN_FUNC: begin
              if (b == cfg.write_all_code) begin
                parse_st = SN_DATA;
              end else begin
                bump(CNT_FUNC_NOT_SUPP);
                restart();
                res.ev = EV_BAD_FUNC;
              end
            end
            SN_DATA: begin
              if (int'(byte_cnt) >= len - 3) parse_st = SN_CHECK;
            end
            SN_CHECK: begin
              if (b == check_acc) begin
                parse_st = SN_STOP;
              end else begin
                bump(CNT_BAD_CHECK);
                restart();
                res.ev = EV_BAD_CHECK;
              end
            end
            SN_STOP: begin
              if (b == cfg.stop_code) begin
                if (to_me) begin
                  bump(CNT_GOOD_TO_ME);
                  res.reply = 1'b1;
                  res.ev = EV_GOOD_OWN;
                end else begin
                  bump(CNT_GOOD_TO_OTHERS);
                  res.ev = EV_GOOD_OTHER;
                end
              end else begin
                bump(CNT_WAIT_STOP);
                res.ev = EV_NO_STOP;
              end
              restart();
            end
            default: begin
              if (b == cfg.start_code) begin
                parse_st = SN_ADDR;
              end else begin
                parse_st = SN_START;
                bump(CNT_WAIT_START);
                res.ev = EV_SKIPPED;
              end
            end
          endcase
          // Every byte inside a frame feeds the running check and the count.
          if (parse_st != SN_START) begin
            check_acc = check_acc ^ b;
            if (byte_cnt < 7'd127) byte_cnt = byte_cnt + 7'd1;
          end
        end
      endcase
      pending_events.push_back(res);
    endfunction

    // Compare one accepted result with the oldest expectation.
    function void check_result(logic [39:0] d);
      frame_result_t want;
      if (pending_events.size() == 0) begin
        $error("result 0x%h arrived with no request outstanding", d);
        errors++;
        return;
      end
      want = pending_events.pop_front();
      if (d[3:0] !== want.ev) begin
        $error("event_res: expected %0d, got %0d", want.ev, d[3:0]);
        errors++;
      end
      if (d[4] !== want.reply) begin
        $error("reply_request: expected %0d, got %0d", want.reply, d[4]);
        errors++;
      end
      if (d[7:5] !== want.prior) begin
        $error("prior_state: expected %0d, got %0d", want.prior, d[7:5]);
        errors++;
      end
      if (d[39:8] !== want.cval) begin
        $error("counter_value: expected %0d, got %0d", want.cval, d[39:8]);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [7:0]  cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  frame_scoreboard sb = new();
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int stall_left = 0;
  int req_count = 0;

  rs485_frame_receiver_core DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk = ~clk;

  // Sender idle length: mostly none or short, now and then long.
  function automatic int idle_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Offer one request and return at the edge that accepts it.
  task automatic send_req(cmd_t c, logic [7:0] b, logic [3:0] ix);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, ix, b};
    s_axis_tuser  <= c;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_request(c, b, ix);
    req_count++;
  endtask

  // Drop valid and wait until every result has come back.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Present one register write for a single edge; the caller drops the enable.
  task automatic write_reg(reg_idx_t r, logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= v;
    @(posedge clk);
    sb.write_reg(r, v);
  endtask

  task automatic set_config(logic [7:0] start_c, logic [7:0] stop_c, logic [7:0] own,
                            logic [7:0] bcast, logic [7:0] wall, logic [7:0] flen);
    wait_idle();
    write_reg(REG_START_CODE, start_c);
    write_reg(REG_STOP_CODE, stop_c);
    write_reg(REG_OWN_ADDRESS, own);
    write_reg(REG_BCAST_ADDR, bcast);
    write_reg(REG_WRITE_ALL, wall);
    write_reg(REG_FRAME_LENGTH, flen);
    cfg_we <= 1'b0;
  endtask

  // Build a frame for the current settings. addr_sel picks own, broadcast
  // or a random address. flip corrupts one bit somewhere in the frame.
  // A nonzero cut sends only that many leading bytes and then a flush.
  task automatic send_frame(int addr_sel, bit flip, int cut);
    logic [7:0] fr [$];
    logic [7:0] chk;
    int len;
    int ndata;
    int pos;
    len = int'(sb.cfg.frame_length);
    if (len > MaxFrameLength) len = MaxFrameLength;
    ndata = (len > 6) ? len - 5 : 1;
    fr.push_back(sb.cfg.start_code);
    case (addr_sel)
      0:       fr.push_back(sb.cfg.own_address);
      1:       fr.push_back(sb.cfg.broadcast_address);
      default: fr.push_back(8'($urandom_range(0, 255)));
    endcase
    fr.push_back(sb.cfg.write_all_code);
    repeat (ndata) fr.push_back(8'($urandom_range(0, 255)));
    chk = CHECK_SEED;
    foreach (fr[i]) chk = chk ^ fr[i];
    fr.push_back(chk);
    fr.push_back(sb.cfg.stop_code);
    if (flip) begin
      pos = $urandom_range(0, fr.size() - 1);
      fr[pos] = fr[pos] ^ 8'(1 << $urandom_range(0, 7));
    end
    if (cut > 0) begin
      while (fr.size() > cut) void'(fr.pop_back());
    end
    foreach (fr[i]) begin
      // Counter reads in mid-frame must leave the parser alone.
      if ($urandom_range(0, 24) == 0)
        send_req(CMD_READ, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
      send_req(CMD_BYTE, fr[i], 4'($urandom_range(0, 15)));
    end
    if (cut > 0) send_req(CMD_FLUSH, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
  endtask

  // Mostly well-formed frames with random content, the rest broken frames
  // and single requests of every kind.
  task automatic run_random(int n);
    int target;
    int r;
    target = req_count + n;
    while (req_count < target) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        send_frame($urandom_range(0, 2), 1'b0, 0);
      end else if (r < 65) begin
        if ($urandom_range(0, 1) == 0) send_frame($urandom_range(0, 2), 1'b1, 0);
        else send_frame($urandom_range(0, 2), 1'b0, $urandom_range(1, 8));
      end else if (r < 80) begin
        send_req(CMD_BYTE, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
      end else if (r < 88) begin
        send_req(CMD_READ, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
      end else if (r < 95) begin
        send_req(CMD_FLUSH, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
      end else if (r < 97) begin
        send_req(CMD_CLEAR, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
      end else begin
        repeat ($urandom_range(2, 6))
          send_req(CMD_BYTE, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
      end
    end
  endtask

  // Random settings, mostly short frames, sometimes own equal to broadcast.
  task automatic random_config();
    logic [7:0] own;
    logic [7:0] bcast;
    logic [7:0] flen;
    own = 8'($urandom_range(0, 255));
    bcast = ($urandom_range(0, 3) == 0) ? own : 8'($urandom_range(0, 255));
    flen = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 5)) : 8'($urandom_range(6, 16));
    set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), own, bcast,
               8'($urandom_range(0, 255)), flen);
  endtask

  // Result side: check each accepted result and stall at random.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 80;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) : $urandom_range(8, 30);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Stimulus and end of run.
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: skipped bytes at both extremes, a flush while idle,
    // a good frame to this node, counter reads in and out of range, clear.
    send_req(CMD_BYTE, 8'h00, 4'h0);
    send_req(CMD_BYTE, 8'hFF, 4'hF);
    send_req(CMD_FLUSH, 8'hA5, 4'h0);
    send_frame(0, 1'b0, 0);
    send_req(CMD_READ, 8'h00, 4'(CNT_GOOD_TO_ME));
    send_req(CMD_READ, 8'hFF, 4'hF);
    send_req(CMD_CLEAR, 8'h5A, 4'h3);
    send_req(CMD_READ, 8'h00, 4'(CNT_WAIT_START));

    // Shortest frames, own equal to broadcast: flush in every parser state past
    // start, then a complete frame to the shared address.
    set_config(8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00);
    for (int k = 1; k <= 5; k++) send_frame(0, 1'b0, k);
    send_frame(1, 1'b0, 0);
    run_random(300);

    // Opposite extremes; an oversized length saturates to the maximum.
    set_config(8'hFF, 8'h00, 8'hFF, 8'hFE, 8'h00, 8'h7F);
    run_random(200);

    // Reset values again, starting with the result side held off long
    // enough that the block fills and stalls its input.
    set_config(8'd126, 8'd127, 8'd1, 8'd255, 8'd1, 8'd12);
    quiet = 1'b1;
    hold_req = 1'b1;
    run_random(40);
    quiet = 1'b0;
    run_random(210);

    // Random settings; the first stretch runs with no idling on either side.
    random_config();
    quiet = 1'b1;
    run_random(60);
    quiet = 1'b0;
    run_random(190);
    random_config();
    run_random(250);
    random_config();
    run_random(250);

    wait_idle();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
